// ===== rtl/lmsp_pkg.sv =====
// Package for the LED matrix shift packer.
// Holds defaults, op and shift-mode codes, and the controller/datapath structs.
// No dependencies.
package lmsp_pkg;

  localparam int unsigned RowsDef = 8;
  localparam int unsigned ColsDef = 8;
  localparam int unsigned MaxOut  = 64;

  localparam int unsigned RowIdxW   = 6;
  localparam int unsigned RowBitsW  = 8;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned InTdataW  = 24;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SHIFT = 1'b1
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE       = 3'd0,
    MODE_DOWN       = 3'd1,
    MODE_UP         = 3'd2,
    MODE_DIAG_WRAP  = 3'd3,
    MODE_DECAY_DOWN = 3'd4,
    MODE_DECAY_UP   = 3'd5,
    MODE_RIGHT      = 3'd6
  } shift_mode_e;

  typedef struct packed {
    logic load_row;
    logic apply_shift;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic is_last;
  } sts_t;

endpackage

// ===== rtl/led_matrix_shift_packer_top.sv =====
// Top level of the LED matrix shift packer.
// Instantiates lmsp_ctrl and lmsp_datapath; depends on lmsp_pkg.
//
//  channel  dir  tdata (low bit up)                          side band
//  s_axis   in   row_index[5:0] row_bits[13:6] mode[16:14]   tuser = op
//  m_axis   out  packed_byte[7:0]                            tlast = last_byte
//
// A load request writes the indexed frame row. A shift request applies the mode and loads
// the shift-out register in its accept cycle, then sends min(ceil(ROWS*COLS/8),
// 64) bytes, one per cycle, counted by the byte counter (8 bytes at 8x8).
// s_axis_tready is low while bytes are sent; m_axis stalls hold the byte.
// rst_ni clears the frame and returns to idle.
module led_matrix_shift_packer_top #(
  parameter int unsigned ROWS = lmsp_pkg::RowsDef,
  parameter int unsigned COLS = lmsp_pkg::ColsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // row_index[5:0], row_bits[13:6], shift_mode[16:14], zeros above
  input  logic [lmsp_pkg::InTdataW-1:0]   s_axis_tdata,
  // op[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // packed_byte[7:0]
  output logic [lmsp_pkg::ByteW-1:0]      m_axis_tdata,
  output logic                            m_axis_tlast
);
  import lmsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lmsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmsp_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .row_index_i   (s_axis_tdata[5:0]),
    .row_bits_i    (s_axis_tdata[13:6]),
    .shift_mode_i  (s_axis_tdata[16:14]),
    .packed_byte_o (m_axis_tdata)
  );

  assign m_axis_tlast = sts.is_last;

endmodule

// ===== rtl/lmsp_ctrl.sv =====
// Controller for the LED matrix shift packer: idle/emit state machine.
// Depends on lmsp_pkg.
module lmsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lmsp_pkg::sts_t    sts_i,
  output lmsp_pkg::cmd_t    cmd_o
);
  import lmsp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (op_e'(in_op_i) == OP_SHIFT)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i && sts_i.is_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = (state_q == ST_EMIT);
  assign cmd_o.load_row    = in_ready_o && in_valid_i && (op_e'(in_op_i) == OP_LOAD);
  assign cmd_o.apply_shift = in_ready_o && in_valid_i && (op_e'(in_op_i) == OP_SHIFT);
  assign cmd_o.advance     = out_valid_o && out_ready_i;

endmodule

// ===== rtl/lmsp_datapath.sv =====
// Datapath for the LED matrix shift packer: frame rows, shift modes,
// packed-byte shift-out register and byte counter. Depends on lmsp_pkg.
module lmsp_datapath #(
  parameter int unsigned ROWS = lmsp_pkg::RowsDef,
  parameter int unsigned COLS = lmsp_pkg::ColsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lmsp_pkg::cmd_t                  cmd_i,
  output lmsp_pkg::sts_t                  sts_o,
  input  logic [lmsp_pkg::RowIdxW-1:0]    row_index_i,
  input  logic [lmsp_pkg::RowBitsW-1:0]   row_bits_i,
  input  logic [lmsp_pkg::ModeW-1:0]      shift_mode_i,
  output logic [lmsp_pkg::ByteW-1:0]      packed_byte_o
);
  import lmsp_pkg::*;

  localparam int unsigned Total    = ROWS * COLS;
  localparam int unsigned NeedB    = (Total + 7) / 8;
  localparam int unsigned NBytes   = (NeedB > MaxOut) ? MaxOut : NeedB;
  localparam int unsigned OutBits  = NBytes * ByteW;
  localparam int unsigned RowAW    = $clog2(ROWS);
  localparam int unsigned CntW     = $clog2(NBytes);

  logic [COLS-1:0]    frame_q [ROWS];
  logic [COLS-1:0]    frame_d [ROWS];
  logic [Total-1:0]   flat;
  logic [OutBits-1:0] sr_load;
  logic [OutBits-1:0] sr_q;
  logic [CntW-1:0]    cnt_q;
  logic               row_ok;

  // Column 0 sits in the row MSB.
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      case (shift_mode_e'(shift_mode_i))
        MODE_DOWN:
          frame_d[i] = frame_q[(i == 0) ? ROWS-1 : i-1];
        MODE_UP:
          frame_d[i] = frame_q[(i == ROWS-1) ? 0 : i+1];
        MODE_DIAG_WRAP: begin
          frame_d[i] = {frame_q[(i == 0) ? ROWS-1 : i-1][0],
                        frame_q[(i == 0) ? ROWS-1 : i-1][COLS-1:1]};
        end
        MODE_DECAY_DOWN: begin
          if (i == 0) frame_d[i] = '0;
          else        frame_d[i] = {1'b0, frame_q[(i == 0) ? 0 : i-1][COLS-1:1]};
        end
        MODE_DECAY_UP: begin
          if (i == ROWS-1) frame_d[i] = '0;
          else if (i == 0) frame_d[i] = {frame_q[0][COLS-1], frame_q[1][COLS-1:1]};
          else frame_d[i] = {1'b0, frame_q[(i == ROWS-1) ? 0 : i+1][COLS-1:1]};
        end
        MODE_RIGHT:
          frame_d[i] = {frame_q[i][0], frame_q[i][COLS-1:1]};
        default:
          frame_d[i] = frame_q[i];
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      flat[Total-1-i*COLS -: COLS] = frame_d[i];
    end
  end

  if (Total >= OutBits) begin : g_trunc
    assign sr_load = flat[Total-1 -: OutBits];
  end else begin : g_pad
    localparam int unsigned Pad = OutBits - Total;
    assign sr_load = {flat, {Pad{1'b0}}};
  end

  assign row_ok = ({1'b0, row_index_i} < (RowIdxW+1)'(ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) frame_q[i] <= '0;
    end else if (cmd_i.apply_shift) begin
      for (int i = 0; i < ROWS; i++) frame_q[i] <= frame_d[i];
    end else if (cmd_i.load_row && row_ok) begin
      frame_q[row_index_i[RowAW-1:0]] <= COLS'(row_bits_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.apply_shift) begin
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_shift) begin
      sr_q <= sr_load;
    end else if (cmd_i.advance) begin
      sr_q <= {sr_q[OutBits-ByteW-1:0], {ByteW{1'b0}}};
    end
  end

  assign packed_byte_o = sr_q[OutBits-1 -: ByteW];
  assign sts_o.is_last = (cnt_q == CntW'(NBytes - 1));

endmodule
